// ===== hw/rtl/qht_pkg.sv =====
// ----------------------------------------------------------------------------
// qht_pkg
// Shared widths, constants and item codes of the quintic homing generator.
// ----------------------------------------------------------------------------
package qht_pkg;

  // joint count and joint table addressing
  localparam int JOINTS = 32;
  localparam int JA_W   = (JOINTS > 1) ? $clog2(JOINTS) : 1;
  localparam int JI_W   = 6;

  // field widths
  localparam int POS_W  = 32;
  localparam int TIME_W = 17;
  localparam int MODE_W = 2;

  // datapath widths: 33-bit difference plus headroom, 34 x 17 product
  localparam int P_W    = 34;
  localparam int PROD_W = P_W + TIME_W;
  localparam int RND_W  = P_W + 2;

  // Q16 constants
  localparam logic [TIME_W-1:0] ONE_Q16 = TIME_W'(65536);
  localparam logic [TIME_W-1:0] STEP_RST = TIME_W'(13);
  localparam logic signed [P_W-1:0] C15 = P_W'(15 * 65536);
  localparam logic signed [RND_W-1:0] C10 = RND_W'(10 * 65536);
  localparam logic [PROD_W:0] HALF_LSB = (PROD_W+1)'(32768);

  // item codes
  typedef enum logic [MODE_W-1:0] {
    MODE_HOME  = 2'd0,
    MODE_START = 2'd1,
    MODE_TICK  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

endpackage

// ===== hw/rtl/quintic_homing_trajectory.sv =====
// Sequence: a tick runs four Horner steps for alpha (S_AMUL, S_AACC), then one result per
// joint (S_JMUL, S_JOUT), all on one shared 34x17 multiplier.
// Joint tables sit in two one-read-port RAMs.
// Throughput: one beat at a time; no beat is taken while a tick is running.
// Reset: rst_n synchronous, clears normalised time, step to 13, control state;
// joint tables are undefined until written.
// ----------------------------------------------------------------------------
// quintic_homing_trajectory
// Minimum-jerk homing: alpha by Horner's rule, then start + alpha*(home-start)
// for every joint, read from the home and start tables.
// ----------------------------------------------------------------------------
module quintic_homing_trajectory import qht_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [TIME_W-1:0]       cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [MODE_W-1:0]       in_mode,
  input  logic [JI_W-1:0]         in_joint,
  input  logic signed [POS_W-1:0] in_position,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [JI_W-1:0]         out_joint_index,
  output logic signed [POS_W-1:0] out_reference,
  output logic                    out_last_joint,
  output logic                    out_done_res
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_AMUL = 5'b00010,
    S_AACC = 5'b00100,
    S_JMUL = 5'b01000,
    S_JOUT = 5'b10000
  } state_t;

  state_t                    state_r, state_nxt;
  logic [TIME_W-1:0]         step_r;
  logic [TIME_W-1:0]         ntime_r, ntime_nxt;
  logic [TIME_W-1:0]         t_r;
  logic                      done_r;
  logic [TIME_W-1:0]         alpha_r;
  logic signed [P_W-1:0]     p_r;
  logic [1:0]                hstep_r;
  logic [JA_W-1:0]           j_r;
  logic [JA_W-1:0]           jcur_r;
  logic [PROD_W-1:0]         prod_r;
  logic                      neg_r;
  logic signed [POS_W-1:0]   start_r;
  logic                      out_valid_r;
  logic [JI_W-1:0]           out_joint_r;
  logic signed [POS_W-1:0]   out_ref_r;
  logic                      out_last_r;
  logic                      out_done_r;

  // joint tables
  logic signed [POS_W-1:0]   home_mem  [JOINTS];
  logic signed [POS_W-1:0]   start_mem [JOINTS];
  logic signed [POS_W-1:0]   home_rd;
  logic signed [POS_W-1:0]   start_rd;

  logic                      in_acc;
  logic                      load_ok;
  logic                      out_free;
  logic                      jlast;
  logic [TIME_W:0]           tsum;
  logic signed [P_W-1:0]     mul_a;
  logic [P_W-1:0]            mul_a_mag;
  logic [TIME_W-1:0]         mul_b;
  logic [PROD_W-1:0]         prod;
  logic [RND_W-1:0]          rnd_mag;
  logic signed [RND_W-1:0]   rnd;
  logic signed [RND_W-1:0]   p_acc;
  logic signed [RND_W-1:0]   ref_sum;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign load_ok  = ({1'b0, in_joint} < (JI_W+1)'(JOINTS));
  assign out_free = !out_valid_r || out_ready;
  assign jlast    = (jcur_r == JA_W'(JOINTS - 1));

  // table writes from load beats, reads at the joint counter
  always_ff @(posedge clk) begin
    if (in_acc && load_ok && (in_mode == MODE_HOME)) begin
      home_mem[in_joint[JA_W-1:0]] <= in_position;
    end
    home_rd <= home_mem[j_r];
  end

  always_ff @(posedge clk) begin
    if (in_acc && load_ok && (in_mode == MODE_START)) begin
      start_mem[in_joint[JA_W-1:0]] <= in_position;
    end
    start_rd <= start_mem[j_r];
  end

  // shared multiplier: magnitude of a signed operand times an unsigned Q16 value
  always_comb begin
    if (state_r == S_JMUL) begin
      mul_a = P_W'($signed({home_rd[POS_W-1], home_rd}) -
                   $signed({start_rd[POS_W-1], start_rd}));
      mul_b = alpha_r;
    end else begin
      mul_a = p_r;
      mul_b = t_r;
    end
    mul_a_mag = mul_a[P_W-1] ? P_W'(-mul_a) : P_W'(mul_a);
    prod      = PROD_W'(mul_a_mag) * PROD_W'(mul_b);
  end

  // round to nearest, ties away from zero, then apply the sign
  always_comb begin
    rnd_mag = RND_W'(((PROD_W+1)'(prod_r) + HALF_LSB) >> 16);
    rnd     = neg_r ? -$signed(rnd_mag) : $signed(rnd_mag);
    p_acc   = (hstep_r == 2'd0) ? (rnd + C10) : rnd;
    ref_sum = RND_W'(start_r) + rnd;
  end

  // normalised time: saturating advance on a tick, clear on a start load
  always_comb begin
    tsum      = (TIME_W+1)'(ntime_r) + (TIME_W+1)'(step_r);
    ntime_nxt = ntime_r;
    if (in_acc && (in_mode == MODE_START)) begin
      ntime_nxt = '0;
    end else if (in_acc && (in_mode == MODE_TICK) && (ntime_r < ONE_Q16)) begin
      ntime_nxt = (tsum > (TIME_W+1)'(ONE_Q16)) ? ONE_Q16 : TIME_W'(tsum);
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && (in_mode == MODE_TICK)) begin
          state_nxt = S_AMUL;
        end
      end
      S_AMUL: state_nxt = S_AACC;
      S_AACC: state_nxt = (hstep_r == 2'd3) ? S_JMUL : S_AMUL;
      S_JMUL: state_nxt = S_JOUT;
      S_JOUT: begin
        if (out_free) begin
          state_nxt = jlast ? S_IDLE : S_JMUL;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  function automatic logic jlast_next(input logic [JA_W-1:0] j);
    return (j == JA_W'(JOINTS - 1));
  endfunction

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= STEP_RST;
      ntime_r     <= '0;
      out_valid_r <= 1'b0;
      hstep_r     <= '0;
      j_r         <= '0;
    end else begin
      state_r <= state_nxt;
      ntime_r <= ntime_nxt;
      if (cfg_we) begin
        step_r <= cfg_wdata;
      end
      // output slot
      if ((state_r == S_JOUT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      // horner step count
      if (state_r == S_IDLE) begin
        hstep_r <= '0;
      end else if (state_r == S_AACC) begin
        hstep_r <= hstep_r + 2'd1;
      end
      // joint read address
      if (in_acc && (in_mode == MODE_TICK)) begin
        j_r <= '0;
      end else if ((state_r == S_JMUL) && !jlast_next(j_r)) begin
        j_r <= j_r + JA_W'(1);
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    // tick setup: snapshot time and start horner with 6t - 15
    if (in_acc && (in_mode == MODE_TICK)) begin
      t_r    <= ntime_r;
      done_r <= (ntime_r >= ONE_Q16);
      p_r    <= $signed(P_W'(ntime_r) * P_W'(6)) - C15;
    end else if (state_r == S_AACC) begin
      p_r <= P_W'(p_acc);
    end
    // clamp alpha to [0, 1] after the last horner step
    if ((state_r == S_AACC) && (hstep_r == 2'd3)) begin
      if (p_acc < 0) begin
        alpha_r <= '0;
      end else if (p_acc > $signed(RND_W'(ONE_Q16))) begin
        alpha_r <= ONE_Q16;
      end else begin
        alpha_r <= TIME_W'(p_acc);
      end
    end
    // product register
    if ((state_r == S_AMUL) || (state_r == S_JMUL)) begin
      prod_r <= prod;
      neg_r  <= mul_a[P_W-1];
    end
    if (state_r == S_JMUL) begin
      start_r <= start_rd;
      jcur_r  <= j_r;
    end
    // result beat
    if ((state_r == S_JOUT) && out_free) begin
      out_joint_r <= JI_W'(jcur_r);
      out_ref_r   <= POS_W'(ref_sum);
      out_last_r  <= jlast;
      out_done_r  <= done_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_joint_index = out_joint_r;
  assign out_reference   = out_ref_r;
  assign out_last_joint  = out_last_r;
  assign out_done_res    = out_done_r;

endmodule
